// ===== src/reb_pkg.sv =====
package reb_pkg;

   localparam int unsigned TIME_BITS_DEF  = 16;
   localparam int unsigned COUNT_BITS_DEF = 8;
   localparam int unsigned CFG_BITS       = 16;
   localparam int unsigned TURN_BITS      = 8;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd4;
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd500;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE   = 1'b0,
      CSR_LONG_PRESS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_NONE    = 2'b00,
      DIR_RIGHT   = 2'b01,
      DIR_LEFT    = 2'b10,
      DIR_INVALID = 2'b11
   } dir_type;

   typedef struct packed {
      logic signed [TURN_BITS-1:0] turns;
      logic                        short_press;
      logic                        key_down;
      logic                        key_held;
   } rsp_word_type;

endpackage

// ===== src/reb_if.sv =====
interface reb_req_if;
   logic valid;
   logic ready;
   logic clock_level;
   logic data_level;
   logic switch_level;
   logic ms_tick;
   logic take_report;

   modport source (output valid, clock_level, data_level, switch_level, ms_tick,
                   take_report, input ready);
   modport sink (input valid, clock_level, data_level, switch_level, ms_tick,
                 take_report, output ready);
endinterface

interface reb_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] turns;
   logic              short_press;
   logic              key_down;
   logic              key_held;

   modport source (output valid, turns, short_press, key_down, key_held,
                   input ready);
   modport sink (input valid, turns, short_press, key_down, key_held,
                 output ready);
endinterface

interface reb_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rotary_encoder_button_decoder.sv =====
// Rotary encoder and push switch decoder.
// req: one word per pin sample: raw active-low encoder clock, data and switch
//   levels, a millisecond tick and a report strobe that clears the turn delta
//   and the short-press flag after the word's result is formed.
// rsp: one word per req word: signed turns since the last report, short
//   press flag, debounced button state and held state.
// csr: writes debounce_ms (index 0) and long_press_ms (index 1); always ready.
//   Write only while no req word is in flight.
// Output: each result is registered, in the output slot or, if that is full, the skid slot.
// Throughput: one word per cycle while rsp keeps up; the decode is a single pass of compares and
//   a counter update between the state registers and the result register.
// Stall: a two-word output buffer lets one more req word in while rsp is
//   stalled; req.ready drops only when both slots are full.
// Reset (synchronous): pins read as released, time base and counters zero,
//   switch released and settled, thresholds 4 ms and 500 ms, output empty.
module rotary_encoder_button_decoder #(
   parameter int unsigned TIME_BITS  = reb_pkg::TIME_BITS_DEF,
   parameter int unsigned COUNT_BITS = reb_pkg::COUNT_BITS_DEF
) (
   input logic   clock,
   input logic   reset,
   reb_req_if.sink   req,
   reb_rsp_if.source rsp,
   reb_csr_if.sink   csr
);
   import reb_pkg::*;

   localparam int unsigned CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

   logic [CFG_BITS-1:0]   debounce_ff, long_press_ff;
   logic [2:0]            prev_pins_ff, prev_pins_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [TIME_BITS-1:0]  change_time_ff, change_time_in;
   logic                  stable_ff, stable_in;
   logic                  pending_ff, pending_in;
   logic                  sw_valid_ff, sw_valid_in;
   logic                  press_ff, press_in, press_out;
   logic [1:0]            rot_ff, rot_in;
   dir_type               dir_ff, dir_in;
   logic [COUNT_BITS-1:0] turn_count_ff, turn_count_in;
   logic [COUNT_BITS-1:0] reported_ff, reported_in;

   rsp_word_type          out_ff, skid_ff, word;
   logic                  out_valid_ff, skid_valid_ff;

   logic                  accept, pop, changed;
   logic                  c, d, s, oc, od;
   logic [2:0]            pins;
   logic [TIME_BITS-1:0]  el_pre, el_post;
   logic signed [COUNT_BITS-1:0] diff;

   assign req.ready = !skid_valid_ff;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign pop       = out_valid_ff && rsp.ready;

   assign pins = {req.switch_level, req.data_level, req.clock_level};
   assign c    = !req.clock_level;
   assign d    = !req.data_level;
   assign s    = !req.switch_level;
   assign oc   = rot_ff[0];
   assign od   = rot_ff[1];

   always_comb begin
      time_in        = req.ms_tick ? time_ff + 1'b1 : time_ff;
      changed        = pins != prev_pins_ff;
      prev_pins_in   = pins;
      change_time_in = change_time_ff;
      stable_in      = stable_ff;
      pending_in     = pending_ff;
      sw_valid_in    = sw_valid_ff;
      press_out      = press_ff;
      rot_in         = rot_ff;
      dir_in         = dir_ff;
      turn_count_in  = turn_count_ff;
      el_pre         = time_in - change_time_ff;

      if (changed) begin
         if (sw_valid_ff) begin
            if (!s && stable_ff)
               press_out = CMP_BITS'(el_pre) < CMP_BITS'(long_press_ff);
            if (s != stable_ff)
               sw_valid_in = 1'b0;
         end
         if (!sw_valid_in) begin
            change_time_in = time_in;
            pending_in     = s;
         end

         if (dir_ff != DIR_INVALID) begin
            if (oc != c && od != d) begin
               dir_in = DIR_INVALID;
            end else if (oc != c || od != d) begin
               if (c && d && dir_ff == DIR_NONE) begin
                  if (oc) begin
                     turn_count_in = turn_count_ff + 1'b1;
                     dir_in        = DIR_RIGHT;
                  end else begin
                     turn_count_in = turn_count_ff - 1'b1;
                     dir_in        = DIR_LEFT;
                  end
               end
               rot_in = {d, c};
               if (!c && !d)
                  dir_in = DIR_NONE;
            end
         end else if (!c && !d) begin
            dir_in = DIR_NONE;
            rot_in = 2'b00;
         end
      end

      el_post = time_in - change_time_in;
      if (!sw_valid_in && CMP_BITS'(el_post) > CMP_BITS'(debounce_ff)) begin
         stable_in   = pending_in;
         sw_valid_in = 1'b1;
      end

      diff             = signed'(turn_count_in - reported_ff);
      word.turns       = TURN_BITS'(diff);
      word.short_press = press_out;
      word.key_down    = stable_in;
      word.key_held    = stable_in && sw_valid_in &&
                         (CMP_BITS'(el_post) > CMP_BITS'(long_press_ff));

      reported_in = reported_ff;
      press_in    = press_out;
      if (req.take_report) begin
         reported_in = turn_count_in;
         press_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
      end else if (csr.valid && csr.ready) begin
         unique case (csr_index_type'(csr.index))
            CSR_DEBOUNCE:   debounce_ff   <= csr.data;
            CSR_LONG_PRESS: long_press_ff <= csr.data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff   <= 3'b111;
         time_ff        <= '0;
         change_time_ff <= '0;
         stable_ff      <= 1'b0;
         pending_ff     <= 1'b0;
         sw_valid_ff    <= 1'b1;
         press_ff       <= 1'b0;
         rot_ff         <= 2'b00;
         dir_ff         <= DIR_NONE;
         turn_count_ff  <= '0;
         reported_ff    <= '0;
      end else if (accept) begin
         prev_pins_ff   <= prev_pins_in;
         time_ff        <= time_in;
         change_time_ff <= change_time_in;
         stable_ff      <= stable_in;
         pending_ff     <= pending_in;
         sw_valid_ff    <= sw_valid_in;
         press_ff       <= press_in;
         rot_ff         <= rot_in;
         dir_ff         <= dir_in;
         turn_count_ff  <= turn_count_in;
         reported_ff    <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            out_ff <= word;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_ff       <= word;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= word;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.turns       = out_ff.turns;
   assign rsp.short_press = out_ff.short_press;
   assign rsp.key_down    = out_ff.key_down;
   assign rsp.key_held    = out_ff.key_held;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output slot");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted word produced no result");

   a_invalid_no_count: assert property (@(posedge clock) disable iff (reset)
      dir_ff == DIR_INVALID |=> $stable(turn_count_ff))
      else $error("turn count moved while decoding invalid");

   a_held_down: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.key_held |-> out_ff.key_down)
      else $error("held reported without button down");

endmodule

// ===== tb/rotary_encoder_button_decoder_test.sv =====
module rotary_encoder_button_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import reb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic clock_level;
      logic data_level;
      logic switch_level;
      logic ms_tick;
      logic take_report;
   } pin_sample_type;

   class decoder_scoreboard;
      logic [CFG_BITS-1:0]       debounce_ms;
      logic [CFG_BITS-1:0]       long_press_ms;
      logic [2:0]                last_pins;
      logic [TIME_BITS_DEF-1:0]  time_now;
      logic [TIME_BITS_DEF-1:0]  change_time;
      bit                        sw_stable;
      bit                        sw_pending;
      bit                        sw_settled;
      bit                        press_flag;
      logic [1:0]                rot_lines;
      dir_type                   dir;
      logic [COUNT_BITS_DEF-1:0] turn_count;
      logic [COUNT_BITS_DEF-1:0] reported_count;
      rsp_word_type              expected_reports[$];
      int                        errors;

      function new();
         debounce_ms    = DEBOUNCE_RESET;
         long_press_ms  = LONG_PRESS_RESET;
         last_pins      = 3'b111;
         time_now       = '0;
         change_time    = '0;
         sw_stable      = 1'b0;
         sw_pending     = 1'b0;
         sw_settled     = 1'b1;
         press_flag     = 1'b0;
         rot_lines      = 2'b00;
         dir            = DIR_NONE;
         turn_count     = '0;
         reported_count = '0;
         errors         = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CFG_BITS-1:0] value);
         case (idx)
            CSR_DEBOUNCE: begin
               debounce_ms = value;
            end
            CSR_LONG_PRESS: begin
               long_press_ms = value;
            end
         endcase
      endfunction

      function logic [TIME_BITS_DEF-1:0] since_change();
         return time_now - change_time;
      endfunction

      // c, d, s are active-high here
      function void pin_change(bit c, bit d, bit s);
         bit oc;
         bit od;
         oc = rot_lines[0];
         od = rot_lines[1];
         if (sw_settled) begin
            if (!s && sw_stable)
               press_flag = (since_change() < long_press_ms);
            if (s != sw_stable)
               sw_settled = 1'b0;
         end
         if (!sw_settled) begin
            change_time = time_now;
            sw_pending  = s;
         end
         if (dir != DIR_INVALID) begin
            if (oc != c && od != d) begin
               dir = DIR_INVALID;
            end else if (oc != c || od != d) begin
               if (c && d && dir == DIR_NONE) begin
                  if (oc) begin
                     turn_count = turn_count + 1'b1;
                     dir        = DIR_RIGHT;
                  end else begin
                     turn_count = turn_count - 1'b1;
                     dir        = DIR_LEFT;
                  end
               end
               rot_lines = {d, c};
               if (rot_lines == 2'b00)
                  dir = DIR_NONE;
            end
         end else if (!c && !d) begin
            dir       = DIR_NONE;
            rot_lines = 2'b00;
         end
      endfunction

      function void note_sample(pin_sample_type w);
         logic [2:0]   pins;
         rsp_word_type r;
         pins = {w.switch_level, w.data_level, w.clock_level};
         if (w.ms_tick)
            time_now = time_now + 1'b1;
         if (pins != last_pins) begin
            pin_change(!w.clock_level, !w.data_level, !w.switch_level);
            last_pins = pins;
         end
         if (!sw_settled && since_change() > debounce_ms) begin
            sw_stable  = sw_pending;
            sw_settled = 1'b1;
         end
         r.turns       = turn_count - reported_count;
         r.short_press = press_flag;
         r.key_down    = sw_stable;
         r.key_held    = sw_stable && sw_settled && (since_change() > long_press_ms);
         expected_reports.push_back(r);
         if (w.take_report) begin
            reported_count = turn_count;
            press_flag     = 1'b0;
         end
      endfunction

      function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
         if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            errors++;
         end
      endfunction

      function void check_report(rsp_word_type got);
         rsp_word_type exp_w;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected rsp word, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         exp_w = expected_reports.pop_front();
         compare_field("turns", exp_w.turns, got.turns);
         compare_field("short_press", exp_w.short_press, got.short_press);
         compare_field("key_down", exp_w.key_down, got.key_down);
         compare_field("key_held", exp_w.key_held, got.key_held);
      endfunction
   endclass

   logic clock;
   logic reset;

   reb_req_if req_bus();
   reb_rsp_if rsp_bus();
   reb_csr_if csr_bus();

   rotary_encoder_button_decoder uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   decoder_scoreboard sb = new();

   bit req_idling    = 1'b1;
   bit rsp_idling    = 1'b1;
   bit report_enable = 1'b1;
   int item_count    = 0;
   int cycle_count   = 0;
   logic cur_clk = 1'b1;
   logic cur_dat = 1'b1;
   logic cur_sw  = 1'b1;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= !rsp_idling || ($urandom_range(0, 99) >= 27);
   end

   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_sample({req_bus.clock_level, req_bus.data_level, req_bus.switch_level,
                            req_bus.ms_tick, req_bus.take_report});
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.turns       = rsp_bus.turns;
            got.short_press = rsp_bus.short_press;
            got.key_down    = rsp_bus.key_down;
            got.key_held    = rsp_bus.key_held;
            sb.check_report(got);
         end
      end
   end

   task automatic push(pin_sample_type w);
      while (req_idling && $urandom_range(0, 99) < 27) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.clock_level  <= w.clock_level;
      req_bus.data_level   <= w.data_level;
      req_bus.switch_level <= w.switch_level;
      req_bus.ms_tick      <= w.ms_tick;
      req_bus.take_report  <= w.take_report;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      item_count++;
   endtask

   task automatic emit();
      push({cur_clk, cur_dat, cur_sw, ($urandom_range(0, 99) < 70) ? 1'b1 : 1'b0,
            (report_enable && $urandom_range(0, 99) < 12) ? 1'b1 : 1'b0});
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_thresholds(logic [CFG_BITS-1:0] debounce,
                                   logic [CFG_BITS-1:0] long_press);
      csr_index_type       idx;
      logic [CFG_BITS-1:0] value;
      for (int n = 0; n < 2; n++) begin
         if (n == 0) begin
            idx   = CSR_DEBOUNCE;
            value = debounce;
         end else begin
            idx   = CSR_LONG_PRESS;
            value = long_press;
         end
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx;
         csr_bus.data  <= value;
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         sb.set_register(idx, value);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // raw {clk, dat} path from rest, optional contact bounce
   task automatic turn_detent(bit clockwise, bit rough);
      logic [1:0] path [0:3];
      logic [1:0] last;
      if (clockwise)
         path = '{2'b01, 2'b00, 2'b10, 2'b11};
      else
         path = '{2'b10, 2'b00, 2'b01, 2'b11};
      if ({cur_clk, cur_dat} != 2'b11) begin
         {cur_clk, cur_dat} = 2'b11;
         emit();
      end
      for (int i = 0; i < 4; i++) begin
         last = {cur_clk, cur_dat};
         if (rough && $urandom_range(0, 99) < 20) begin
            {cur_clk, cur_dat} = path[i];
            emit();
            {cur_clk, cur_dat} = last;
            emit();
         end
         {cur_clk, cur_dat} = path[i];
         repeat ($urandom_range(1, rough ? 3 : 1)) emit();
      end
   endtask

   task automatic press_button(int hold);
      repeat ($urandom_range(0, 3)) begin
         cur_sw = ~cur_sw;
         emit();
      end
      cur_sw = 1'b0;
      repeat (hold) emit();
      repeat ($urandom_range(0, 3)) begin
         cur_sw = ~cur_sw;
         emit();
      end
      cur_sw = 1'b1;
      repeat ($urandom_range(4, 10)) emit();
   endtask

   task automatic run_random(int n);
      int target;
      int pick;
      target = item_count + n;
      while (item_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            turn_detent(1'($urandom_range(0, 1)), 1'b1);
         end else if (pick < 65) begin
            press_button(($urandom_range(0, 99) < 70) ? $urandom_range(1, 30)
                                                        : $urandom_range(35, 90));
         end else if (pick < 75) begin
            {cur_clk, cur_dat} = ~{cur_clk, cur_dat};
            emit();
            repeat ($urandom_range(0, 3)) begin
               {cur_clk, cur_dat} = 2'($urandom_range(0, 3));
               emit();
            end
            {cur_clk, cur_dat} = 2'b11;
            emit();
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 5)) begin
               {cur_clk, cur_dat, cur_sw} = 3'($urandom_range(0, 7));
               emit();
            end
         end else begin
            repeat ($urandom_range(1, 8)) emit();
         end
      end
   endtask

   task automatic directed();
      push(5'b11110);
      // one detent clockwise, then one counter-clockwise
      push(5'b01100);
      push(5'b00100);
      push(5'b10100);
      push(5'b11101);
      push(5'b10100);
      push(5'b00100);
      push(5'b01100);
      push(5'b11100);
      // both lines at once, invalid until rest
      push(5'b00100);
      push(5'b10100);
      push(5'b11101);
      // debounced short press
      push(5'b11010);
      repeat (5) push(5'b11010);
      push(5'b11110);
      repeat (4) push(5'b11110);
      push(5'b11111);
   endtask

   initial begin
      bit spin_dir;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.clock_level  <= 1'b1;
      req_bus.data_level   <= 1'b1;
      req_bus.switch_level <= 1'b1;
      req_bus.ms_tick      <= 1'b0;
      req_bus.take_report  <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_DEBOUNCE;
      csr_bus.data         <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed();
      drain();

      write_thresholds(16'd0, 16'd0);
      // long spin without reports wraps the signed turn delta
      report_enable = 1'b0;
      spin_dir = 1'($urandom_range(0, 1));
      repeat (140) turn_detent(spin_dir, 1'b0);
      report_enable = 1'b1;
      run_random(150);
      drain();

      write_thresholds(16'hFFFF, 16'hFFFF);
      run_random(100);
      drain();

      write_thresholds(16'd3, 16'd40);
      run_random(350);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      run_random(200);
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      run_random(350);
      drain();

      // steady hold well past the held threshold
      write_thresholds(16'd2, 16'd200);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      {cur_clk, cur_dat} = 2'b11;
      cur_sw = 1'b0;
      repeat (300)
         push({cur_clk, cur_dat, cur_sw, 1'b1, ($urandom_range(0, 99) < 2) ? 1'b1 : 1'b0});
      cur_sw = 1'b1;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      repeat (10) emit();
      drain();
      repeat (5) @(posedge clock);

      if (sb.errors == 0 && sb.expected_reports.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/reb_pkg.sv
src/reb_if.sv
src/rotary_encoder_button_decoder.sv
tb/rotary_encoder_button_decoder_test.sv
